// ===== rtl/drc_pkg.sv =====
// Shared constants, command and status types for the depth row centroid core.
package drc_pkg;

	localparam int ROWS = 480;
	localparam int COLS = 640;

	localparam int DEPTH_W  = 16;
	localparam int CLASS_W  = 2;
	localparam int COL_W    = 10;
	localparam int SUM_W    = 18;
	localparam int CNT_W    = 10;
	localparam int FSUM_W   = 23;
	localparam int Q_W      = 14;
	localparam int FRAC_W   = 4;

	localparam int DIV_DW   = FSUM_W;
	localparam int DIV_VW   = 11;
	localparam int DIV_CW   = $clog2(DIV_DW + 1);

	// The frame sum is divided by ROWS through a multiplication by a rounded-up
	// reciprocal, which is exact for every frame sum of FSUM_W bits.
	localparam int ROWS_SH  = FSUM_W + $clog2(ROWS);
	localparam int RECIP_W  = FSUM_W + 1;
	localparam int PROD_W   = FSUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] ROWS_RECIP =
		RECIP_W'(((64'd1 << ROWS_SH) + 64'(ROWS - 1)) / 64'(ROWS));

	localparam logic [DEPTH_W-1:0] THRESH_RESET = DEPTH_W'(450);

	localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FAR  = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_NEAR = 2'd2;

	typedef struct packed {
		logic accept;
		logic row_finish;
		logic frame_start;
		logic frame_finish;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic end_row;
		logic row_div_needed;
		logic frame_end;
		logic frame_pend;
		logic div_busy;
	} dp_stat_t;

endpackage

// ===== rtl/drc_ctrl.sv =====
// Controller state machine that sequences pixel requests, divisions and result delivery.
module drc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  drc_pkg::dp_stat_t stat,
	output drc_pkg::dp_cmd_t  cmd
);
	import drc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE        = 5'b00001,
		ST_ROW_DIV     = 5'b00010,
		ST_FRAME_START = 5'b00100,
		ST_FRAME_DIV   = 5'b01000,
		ST_WAIT_OUT    = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.accept       = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept && stat.end_row) begin
					if (stat.row_div_needed) begin
						state_d = ST_ROW_DIV;
					end else if (stat.frame_end) begin
						state_d = ST_FRAME_START;
					end else begin
						state_d = ST_WAIT_OUT;
					end
				end
			end
			ST_ROW_DIV: begin
				if (!stat.div_busy) begin
					cmd.row_finish = 1'b1;
					state_d = stat.frame_pend ? ST_FRAME_START : ST_WAIT_OUT;
				end
			end
			ST_FRAME_START: begin
				cmd.frame_start = 1'b1;
				state_d = ST_FRAME_DIV;
			end
			ST_FRAME_DIV: begin
				if (!stat.div_busy) begin
					cmd.frame_finish = 1'b1;
					state_d = ST_WAIT_OUT;
				end
			end
			ST_WAIT_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out || (accept && !stat.end_row)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE))
		else $error("input ready outside idle state");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> (state_q == ST_ROW_DIV || state_q == ST_FRAME_DIV))
		else $error("divider busy outside a division state");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT_OUT) |-> $past(state_q) != ST_IDLE || $past(accept))
		else $error("wait state entered without a request");
`endif

endmodule

// ===== rtl/drc_datapath.sv =====
// Datapath: classifier, row and frame accumulators, row divider, frame multiplier and output register.
module drc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [drc_pkg::DEPTH_W-1:0]   cfg_thresh,
	input  logic [drc_pkg::DEPTH_W-1:0]   depth_mm,
	input  logic                          row_end,
	input  logic                          frame_end,
	input  drc_pkg::dp_cmd_t              cmd,
	output drc_pkg::dp_stat_t             stat,
	output logic [drc_pkg::CLASS_W-1:0]   pixel_class,
	output logic                          row_done,
	output logic                          row_valid,
	output logic [drc_pkg::COL_W-1:0]     row_center,
	output logic                          frame_done,
	output logic                          frame_valid,
	output logic [drc_pkg::Q_W-1:0]       frame_center
);
	import drc_pkg::*;

	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
	localparam logic [Q_W-1:0]    Q_MAX    = '1;

	logic [DEPTH_W-1:0] thresh_q;
	logic [COL_W-1:0]   col_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FSUM_W-1:0]  fsum_q;
	logic               fbad_q;

	logic [CLASS_W-1:0] pend_class_q;
	logic               pend_frame_q;
	logic               pend_row_valid_q;
	logic [COL_W-1:0]   pend_row_center_q;
	logic               pend_frame_valid_q;
	logic [Q_W-1:0]     pend_frame_center_q;

	logic [DIV_VW-1:0]  div_rem_q;
	logic [DIV_DW-1:0]  div_quo_q;
	logic [DIV_VW-1:0]  div_den_q;
	logic [DIV_CW-1:0]  div_cnt_q;
	logic [PROD_W-1:0]  frame_prod_q;

	logic [CLASS_W-1:0] cls;
	logic               near;
	logic               end_row;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_new;
	logic [CNT_W-1:0]   cnt_new;
	logic [DIV_VW:0]    trial;
	logic               trial_ok;
	logic [Q_W-1:0]     quo_clamp;
	logic [FSUM_W:0]    fsum_wide;
	logic [PROD_W-1:0]  frame_quo;
	logic [Q_W-1:0]     frame_clamp;

	assign near = (depth_mm != '0) && (depth_mm < thresh_q);

	always_comb begin
		if (depth_mm == '0) begin
			cls = CLASS_NONE;
		end else if (near) begin
			cls = CLASS_NEAR;
		end else begin
			cls = CLASS_FAR;
		end
	end

	assign end_row  = row_end || frame_end;
	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(col_q);

	always_comb begin
		sum_new = sum_q;
		cnt_new = cnt_q;
		if (near) begin
			sum_new = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
			if (cnt_q != '1) begin
				cnt_new = cnt_q + 1'b1;
			end
		end
	end

	assign trial     = {div_rem_q, div_quo_q[DIV_DW-1]};
	assign trial_ok  = trial >= {1'b0, div_den_q};
	assign quo_clamp = (|div_quo_q[DIV_DW-1:Q_W]) ? Q_MAX : div_quo_q[Q_W-1:0];
	assign fsum_wide = {1'b0, fsum_q} + (FSUM_W + 1)'(quo_clamp);

	assign frame_quo   = frame_prod_q >> ROWS_SH;
	assign frame_clamp = (frame_quo > PROD_W'(Q_MAX)) ? Q_MAX : frame_quo[Q_W-1:0];

	assign stat.end_row        = end_row;
	assign stat.row_div_needed = cnt_new != '0;
	assign stat.frame_end      = frame_end;
	assign stat.frame_pend     = pend_frame_q;
	assign stat.div_busy       = div_cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= THRESH_RESET;
			col_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			fsum_q    <= '0;
			fbad_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_write) begin
				thresh_q <= cfg_thresh;
			end
			if (cmd.accept) begin
				if (end_row) begin
					col_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
					if (cnt_new == '0) begin
						fbad_q <= 1'b1;
					end else begin
						div_cnt_q <= DIV_CW'(DIV_DW);
					end
				end else begin
					col_q <= (col_q == COL_LAST) ? '0 : col_q + 1'b1;
					sum_q <= sum_new;
					cnt_q <= cnt_new;
				end
			end
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.row_finish) begin
				fsum_q <= fsum_wide[FSUM_W] ? '1 : fsum_wide[FSUM_W-1:0];
			end
			if (cmd.frame_finish) begin
				fsum_q <= '0;
				fbad_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && end_row) begin
			div_rem_q <= '0;
			div_quo_q <= DIV_DW'({sum_new, {FRAC_W{1'b0}}});
			div_den_q <= DIV_VW'(cnt_new);
		end else if (div_cnt_q != '0) begin
			div_rem_q <= trial_ok ? DIV_VW'(trial - {1'b0, div_den_q}) : trial[DIV_VW-1:0];
			div_quo_q <= {div_quo_q[DIV_DW-2:0], trial_ok};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_start) begin
			frame_prod_q <= PROD_W'(fsum_q) * PROD_W'(ROWS_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_class_q        <= cls;
			pend_frame_q        <= frame_end;
			pend_row_valid_q    <= 1'b0;
			pend_row_center_q   <= '0;
			pend_frame_valid_q  <= 1'b0;
			pend_frame_center_q <= '0;
		end
		if (cmd.row_finish) begin
			pend_row_valid_q  <= 1'b1;
			pend_row_center_q <= quo_clamp[Q_W-1:FRAC_W];
		end
		if (cmd.frame_finish) begin
			pend_frame_valid_q  <= !fbad_q;
			pend_frame_center_q <= fbad_q ? '0 : frame_clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !end_row) begin
			pixel_class  <= cls;
			row_done     <= 1'b0;
			row_valid    <= 1'b0;
			row_center   <= '0;
			frame_done   <= 1'b0;
			frame_valid  <= 1'b0;
			frame_center <= '0;
		end else if (cmd.load_out) begin
			pixel_class  <= pend_class_q;
			row_done     <= 1'b1;
			row_valid    <= pend_row_valid_q;
			row_center   <= pend_row_center_q;
			frame_done   <= pend_frame_q;
			frame_valid  <= pend_frame_valid_q;
			frame_center <= pend_frame_center_q;
		end
	end

endmodule

// ===== rtl/depth_row_centroid_core.sv =====
// Top level of the depth row centroid core: ports, controller and datapath.
// A pixel that does not end a row is taken and its class is returned
// through the output register, so such pixels stream at one per cycle
// while results are taken. A pixel that ends a row holds the input while
// the 23-step restoring divider forms the Q10.4 row centroid; a pixel that
// ends the frame holds it longer, as a registered multiplication by the
// reciprocal of ROWS then divides the frame sum. A row end with no near
// pixel skips the divider. A result that is not taken holds the input until
// it is taken. The threshold register may be written at any time the core
// is idle and is always ready.
module depth_row_centroid_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [drc_pkg::DEPTH_W-1:0]   near_threshold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [drc_pkg::DEPTH_W-1:0]   depth_mm,
	input  logic                          row_end,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [drc_pkg::CLASS_W-1:0]   pixel_class,
	output logic                          row_done,
	output logic                          row_valid,
	output logic [drc_pkg::COL_W-1:0]     row_center,
	output logic                          frame_done,
	output logic                          frame_valid,
	output logic [drc_pkg::Q_W-1:0]       frame_center
);
	import drc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	drc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	drc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_thresh   (near_threshold),
		.depth_mm     (depth_mm),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.cmd          (cmd),
		.stat         (stat),
		.pixel_class  (pixel_class),
		.row_done     (row_done),
		.row_valid    (row_valid),
		.row_center   (row_center),
		.frame_done   (frame_done),
		.frame_valid  (frame_valid),
		.frame_center (frame_center)
	);

endmodule
